// ===== design/gdfs_pkg.sv =====
// Shared types and constants of the grid depth-first search walker.
// No dependencies; imported by every module of the block.
`default_nettype none
package gdfs_pkg;

  localparam int CoordW  = 6;
  localparam int SizeW   = 7;
  localparam int CfgIdxW = 3;
  localparam int StatusW = 3;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [SizeW-1:0]   size_t;
  typedef logic [StatusW-1:0] status_t;

  // action codes of an input item
  localparam logic [1:0] ActLoad    = 2'd0;
  localparam logic [1:0] ActRestart = 2'd1;
  localparam logic [1:0] ActStep    = 2'd2;
  localparam logic [1:0] ActTrace   = 2'd3;

  // result status codes
  localparam status_t StLooking = 3'd0;
  localparam status_t StReached = 3'd1;
  localparam status_t StUnreach = 3'd2;
  localparam status_t StPath    = 3'd3;
  localparam status_t StPathEnd = 3'd4;
  localparam status_t StAck     = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMapWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMapHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartCol  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartRow  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGoalCol   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGoalRow   = 3'd5;

  // cell reference with a valid flag (parent entries, trace cursor)
  typedef struct packed {
    logic   vld;
    coord_t col;
    coord_t row;
  } cell_ref_t;

  // write enables toward the cell stores
  typedef struct packed {
    logic obs;
    logic vis;
    logic par;
  } store_we_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_START,
    S_POP,
    S_CLOSE,
    S_NRD,
    S_NCHK,
    S_TRD,
    S_TCHK,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

// ===== design/gdfs_nbr.sv =====
// Neighbour address unit: one of eight directions of a cell, with bounds check.
// Depends on gdfs_pkg.
`default_nettype none
module gdfs_nbr (
  input  gdfs_pkg::coord_t col_i,
  input  gdfs_pkg::coord_t row_i,
  input  logic [2:0]       dir_i,
  input  gdfs_pkg::size_t  width_i,
  input  gdfs_pkg::size_t  height_i,
  output logic             valid_o,
  output gdfs_pkg::coord_t col_o,
  output gdfs_pkg::coord_t row_o
);
  import gdfs_pkg::*;

  logic east, south, west, north;

  always_comb begin
    east  = ({1'b0, col_i} + 7'd1) < width_i;
    south = ({1'b0, row_i} + 7'd1) < height_i;
    west  = col_i != '0;
    north = row_i != '0;
    valid_o = 1'b0;
    col_o   = col_i;
    row_o   = row_i;
    // order: E, SE, S, SW, W, NW, N, NE
    case (dir_i)
      3'd0: begin
        valid_o = east;
        col_o   = col_i + 6'd1;
      end
      3'd1: begin
        valid_o = east & south;
        col_o   = col_i + 6'd1;
        row_o   = row_i + 6'd1;
      end
      3'd2: begin
        valid_o = south;
        row_o   = row_i + 6'd1;
      end
      3'd3: begin
        valid_o = south & west;
        col_o   = col_i - 6'd1;
        row_o   = row_i + 6'd1;
      end
      3'd4: begin
        valid_o = west;
        col_o   = col_i - 6'd1;
      end
      3'd5: begin
        valid_o = west & north;
        col_o   = col_i - 6'd1;
        row_o   = row_i - 6'd1;
      end
      3'd6: begin
        valid_o = north;
        row_o   = row_i - 6'd1;
      end
      default: begin
        valid_o = north & east;
        col_o   = col_i + 6'd1;
        row_o   = row_i - 6'd1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/gdfs_store.sv =====
// Per-cell stores: obstacle bit, visited bit and parent entry, one shared port.
// Read data is registered. Depends on gdfs_pkg.
`default_nettype none
module gdfs_store #(
  parameter int AW = 12
) (
  input  logic                clk_i,
  input  logic [AW-1:0]       addr_i,
  input  gdfs_pkg::store_we_t we_i,
  input  logic                obs_i,
  input  logic                vis_i,
  input  gdfs_pkg::cell_ref_t par_i,
  output logic                obs_o,
  output logic                vis_o,
  output gdfs_pkg::cell_ref_t par_o
);
  import gdfs_pkg::*;

  logic      obs_mem [2**AW];
  logic      vis_mem [2**AW];
  cell_ref_t par_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i.obs) obs_mem[addr_i] <= obs_i;
    if (we_i.vis) vis_mem[addr_i] <= vis_i;
    if (we_i.par) par_mem[addr_i] <= par_i;
    obs_o <= obs_mem[addr_i];
    vis_o <= vis_mem[addr_i];
    par_o <= par_mem[addr_i];
  end

endmodule
`default_nettype wire

// ===== design/grid_dfs_path_walker.sv =====
// Top level of the grid depth-first search walker: sequencer, stack, registers.
// Depends on gdfs_pkg, gdfs_nbr and gdfs_store.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_stall_o | action, cell_col, cell_row, blocked
//   out     | output    | out_valid_o/out_stall_i | status, node_col, node_row
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A search step pops the top of the stack; unless the popped cell is the goal, it
// then checks each in-bounds neighbour and skips each out-of-bounds one: each
// neighbour is one registered read of the cell store.
// Restart sweeps all 2**(CW+RW) cells (4096 by default) one per cycle.
// After reset the same sweep clears all three cell stores; in_stall_o stays high.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module grid_dfs_path_walker #(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int STACK_DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  gdfs_pkg::coord_t         cell_col_i,
  input  gdfs_pkg::coord_t         cell_row_i,
  input  logic                     blocked_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output gdfs_pkg::status_t        status_o,
  output gdfs_pkg::coord_t         node_col_o,
  output gdfs_pkg::coord_t         node_row_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [gdfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  gdfs_pkg::size_t          cfg_data_i
);
  import gdfs_pkg::*;

  localparam int CW      = $clog2(MAX_COLS);
  localparam int RW      = $clog2(MAX_ROWS);
  localparam int AW      = CW + RW;
  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int SCW     = $clog2(STACK_DEPTH + 1);
  localparam int COL_LIM = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  function automatic logic [AW-1:0] cell_addr(coord_t col, coord_t row);
    return {RW'(row), CW'(col)};
  endfunction

  // configuration
  size_t  map_w_q, map_h_q;
  coord_t start_col_q, start_row_q, goal_col_q, goal_row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q     <= 7'd64;
      map_h_q     <= 7'd64;
      start_col_q <= '0;
      start_row_q <= '0;
      goal_col_q  <= 6'd63;
      goal_row_q  <= 6'd63;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMapWidth:  map_w_q     <= cfg_data_i;
        RegMapHeight: map_h_q     <= cfg_data_i;
        RegStartCol:  start_col_q <= cfg_data_i[CoordW-1:0];
        RegStartRow:  start_row_q <= cfg_data_i[CoordW-1:0];
        RegGoalCol:   goal_col_q  <= cfg_data_i[CoordW-1:0];
        RegGoalRow:   goal_row_q  <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  size_t used_w, used_h;
  coord_t sc, sr;

  always_comb begin
    if (map_w_q == '0)                 used_w = 7'd1;
    else if (map_w_q > SizeW'(COL_LIM)) used_w = SizeW'(COL_LIM);
    else                               used_w = map_w_q;
    if (map_h_q == '0)                 used_h = 7'd1;
    else if (map_h_q > SizeW'(ROW_LIM)) used_h = SizeW'(ROW_LIM);
    else                               used_h = map_h_q;
    sc = ({1'b0, start_col_q} < used_w) ? start_col_q : CoordW'(used_w - 7'd1);
    sr = ({1'b0, start_row_q} < used_h) ? start_row_q : CoordW'(used_h - 7'd1);
  end

  // sequencer registers
  state_e          state_q, state_d;
  logic [1:0]      act_q;
  coord_t          ccol_q, crow_q;
  logic            blk_q;
  logic [SCW-1:0]  cnt_q, cnt_d;
  cell_ref_t       cur_q, cur_d;
  coord_t          pc_q, pc_d, pr_q, pr_d;
  logic [2:0]      k_q, k_d;
  logic [AW-1:0]   sweep_q, sweep_d;
  logic            clr_obs_q, clr_obs_d;
  status_t         res_st_q, res_st_d;
  coord_t          res_col_q, res_col_d, res_row_q, res_row_d;
  logic            out_vld_q, out_vld_d;
  status_t         out_st_q;
  coord_t          out_col_q, out_row_q;

  // neighbour unit
  logic   nb_vld;
  coord_t nb_col, nb_row;

  gdfs_nbr u_nbr (
    .col_i    (pc_q),
    .row_i    (pr_q),
    .dir_i    (k_q),
    .width_i  (used_w),
    .height_i (used_h),
    .valid_o  (nb_vld),
    .col_o    (nb_col),
    .row_o    (nb_row)
  );

  // cell stores
  logic [AW-1:0] st_addr;
  store_we_t     st_we;
  logic          st_obs_wd, st_vis_wd;
  cell_ref_t     st_par_wd;
  logic          st_obs, st_vis;
  cell_ref_t     st_par;

  gdfs_store #(.AW(AW)) u_store (
    .clk_i  (clk_i),
    .addr_i (st_addr),
    .we_i   (st_we),
    .obs_i  (st_obs_wd),
    .vis_i  (st_vis_wd),
    .par_i  (st_par_wd),
    .obs_o  (st_obs),
    .vis_o  (st_vis),
    .par_o  (st_par)
  );

  // open stack
  logic [2*CoordW-1:0] stk_mem [STACK_DEPTH];
  logic                stk_we;
  logic [SAW-1:0]      stk_waddr;
  logic [2*CoordW-1:0] stk_wd, stk_rd_q;

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wd;
    stk_rd_q <= stk_mem[cnt_q[SAW-1:0]];
  end

  logic out_free, load_ok, is_goal, nb_open;

  always_comb begin
    out_free = !out_vld_q || !out_stall_i;
    load_ok  = ({26'd0, ccol_q} < 32'(MAX_COLS)) && ({26'd0, crow_q} < 32'(MAX_ROWS));
    is_goal  = (stk_rd_q[2*CoordW-1:CoordW] == goal_col_q) &&
               (stk_rd_q[CoordW-1:0] == goal_row_q);
    nb_open  = !st_obs && !st_vis;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (sweep_q == '1) state_d = clr_obs_q ? S_IDLE : S_START;
      S_IDLE:  if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        unique case (act_q)
          ActLoad:    state_d = S_FIN;
          ActRestart: state_d = S_CLR;
          ActStep:    state_d = (cnt_q == '0) ? S_FIN : S_POP;
          default:    state_d = cur_q.vld ? S_TRD : S_FIN;
        endcase
      end
      S_START: state_d = S_FIN;
      S_POP:   state_d = S_CLOSE;
      S_CLOSE: state_d = is_goal ? S_FIN : S_NRD;
      S_NRD: begin
        if (nb_vld)           state_d = S_NCHK;
        else if (k_q == 3'd7) state_d = S_FIN;
      end
      S_NCHK:  state_d = (k_q == 3'd7) ? S_FIN : S_NRD;
      S_TRD:   state_d = S_TCHK;
      S_TCHK:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    pc_d      = pc_q;
    pr_d      = pr_q;
    k_d       = k_q;
    sweep_d   = sweep_q;
    clr_obs_d = clr_obs_q;
    res_st_d  = res_st_q;
    res_col_d = res_col_q;
    res_row_d = res_row_q;
    st_addr   = cell_addr(ccol_q, crow_q);
    st_we     = '0;
    st_obs_wd = blk_q;
    st_vis_wd = 1'b1;
    st_par_wd = '{vld: 1'b1, col: pc_q, row: pr_q};
    stk_we    = 1'b0;
    stk_waddr = cnt_q[SAW-1:0];
    stk_wd    = {nb_col, nb_row};
    unique case (state_q)
      S_CLR: begin
        st_addr   = sweep_q;
        st_we     = '{obs: clr_obs_q, vis: 1'b1, par: 1'b1};
        st_obs_wd = 1'b0;
        st_vis_wd = 1'b0;
        st_par_wd = '0;
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == '1) clr_obs_d = 1'b0;
      end
      S_DISP: begin
        unique case (act_q)
          ActLoad: begin
            st_we.obs = load_ok;
            res_st_d  = StAck;
            res_col_d = ccol_q;
            res_row_d = crow_q;
          end
          ActRestart: begin
            sweep_d   = '0;
            clr_obs_d = 1'b0;
          end
          ActStep: begin
            if (cnt_q == '0) begin
              res_st_d  = StUnreach;
              res_col_d = '0;
              res_row_d = '0;
            end else begin
              cnt_d = cnt_q - SCW'(1);
            end
          end
          default: begin
            if (!cur_q.vld) begin
              res_st_d  = StPathEnd;
              res_col_d = '0;
              res_row_d = '0;
            end
          end
        endcase
      end
      S_START: begin
        st_addr   = cell_addr(sc, sr);
        st_we.vis = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wd    = {sc, sr};
        cnt_d     = SCW'(1);
        cur_d     = '0;
        res_st_d  = StAck;
        res_col_d = sc;
        res_row_d = sr;
      end
      S_CLOSE: begin
        pc_d      = stk_rd_q[2*CoordW-1:CoordW];
        pr_d      = stk_rd_q[CoordW-1:0];
        st_addr   = cell_addr(pc_d, pr_d);
        st_we.vis = 1'b1;
        cur_d     = '{vld: 1'b1, col: pc_d, row: pr_d};
        k_d       = '0;
        res_st_d  = is_goal ? StReached : StLooking;
        res_col_d = pc_d;
        res_row_d = pr_d;
      end
      S_NRD: begin
        st_addr = cell_addr(nb_col, nb_row);
        if (!nb_vld) k_d = k_q + 3'd1;
      end
      S_NCHK: begin
        st_addr = cell_addr(nb_col, nb_row);
        if (nb_open) begin
          // drop the push on a full stack, keep the parent
          if (cnt_q < SCW'(STACK_DEPTH)) begin
            stk_we = 1'b1;
            cnt_d  = cnt_q + SCW'(1);
          end
          st_we.par = !st_par.vld;
        end
        k_d = k_q + 3'd1;
      end
      S_TRD: st_addr = cell_addr(cur_q.col, cur_q.row);
      S_TCHK: begin
        st_addr = cell_addr(cur_q.col, cur_q.row);
        if (st_par.vld) begin
          res_st_d  = StPath;
          res_col_d = cur_q.col;
          res_row_d = cur_q.row;
        end else begin
          res_st_d  = StPathEnd;
          res_col_d = '0;
          res_row_d = '0;
        end
        cur_d = st_par;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (state_q == S_FIN && out_free) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      cur_q     <= '0;
      sweep_q   <= '0;
      clr_obs_q <= 1'b1;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      sweep_q   <= sweep_d;
      clr_obs_q <= clr_obs_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q  <= action_i;
      ccol_q <= cell_col_i;
      crow_q <= cell_row_i;
      blk_q  <= blocked_i;
    end
    pc_q      <= pc_d;
    pr_q      <= pr_d;
    res_st_q  <= res_st_d;
    res_col_q <= res_col_d;
    res_row_q <= res_row_d;
    if (state_q == S_FIN && out_free) begin
      out_st_q  <= res_st_q;
      out_col_q <= res_col_q;
      out_row_q <= res_row_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign node_col_o  = out_col_q;
  assign node_row_o  = out_row_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_close_sets_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLOSE |=> cur_q.vld)
    else $error("cursor not set after pop");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_vld_q && out_stall_i) |=> state_q == S_FIN)
    else $error("result left while output register busy");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> out_vld_q)
    else $error("finished result not presented");

endmodule
`default_nettype wire
